// ----- rtl/selb_pkg.sv -----
// Shared types and constants for the sorted event log buffer.
// Used by selb_cell and sorted_event_log_buffer_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package selb_pkg;

    localparam int DEPTH_DEF   = 64;
    localparam int CAP_W       = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] MODE_RECORD = 2'd0;
    localparam logic [1:0] MODE_RANGE  = 2'd1;
    localparam logic [1:0] MODE_ACTOR  = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] RES_ACK   = 2'd0;
    localparam logic [1:0] RES_ENTRY = 2'd1;
    localparam logic [1:0] RES_EMPTY = 2'd2;

    typedef struct packed {
        logic [31:0]        time_s;
        logic [15:0]        actor;
        logic [3:0]         kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        payload;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_SHIFT  = 2'd1,
        OP_INSERT = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] key;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/selb_cell.sv -----
// One storage cell of the sorted chain: holds one entry and moves it
// to or from its neighbours. Depends on selb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module selb_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire logic                clk,
    input  wire selb_pkg::cell_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]    fill,
    input  wire selb_pkg::entry_t    new_entry,
    input  wire selb_pkg::entry_t    head_entry,
    input  wire selb_pkg::entry_t    left_entry,
    input  wire logic                left_after,
    input  wire selb_pkg::entry_t    right_entry,
    output selb_pkg::entry_t         entry,
    output logic                     after
);

    selb_pkg::entry_t entry_reg;
    selb_pkg::entry_t entry_next;

    // this slot lies at or past the insert point
    assign after = (CNT_W'(IDX) >= fill) || (entry_reg.time_s > ctrl.key);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            selb_pkg::OP_SHIFT:
            begin
                entry_next = right_entry;
            end
            selb_pkg::OP_INSERT:
            begin
                if (left_after)
                    entry_next = left_entry;
                else if (after)
                    entry_next = new_entry;
            end
            selb_pkg::OP_ROTATE:
            begin
                // wrap the head round into the last occupied slot
                if (fill == CNT_W'(IDX + 1))
                    entry_next = head_entry;
                else
                    entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

// ----- rtl/sorted_event_log_buffer_top.sv -----
// Top level of the sorted event log buffer: a chain of selb_cell entries
// with the sequencer and output register. Depends on selb_pkg, selb_cell.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to DEPTH event records sorted by time in a chain of cells. A record
// passes through capture, evict, insert and answer; a clear through capture and
// answer. A query rotates the chain one cell per cycle unless a held match waits
// on a stalled output, and emits each match once the next one is found or the
// scan ends. One item is worked on at a time; the next input is taken once the
// last result of the current one is in the output register.
module sorted_event_log_buffer_top #(
    parameter int DEPTH = selb_pkg::DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [6:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [31:0]        event_time,
    input  wire logic [31:0]        current_time,
    input  wire logic [31:0]        range_end,
    input  wire logic [15:0]        actor_id,
    input  wire logic [3:0]         event_kind,
    input  wire logic [4:0]         kind_filter,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic [31:0]        payload,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              result_kind,
    output logic [31:0]             out_time,
    output logic [15:0]             out_actor,
    output logic [3:0]              out_kind,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [31:0]             out_payload,
    output logic [6:0]              entry_count,
    output logic [31:0]             oldest_time,
    output logic [31:0]             newest_time,
    output logic                    last_of_run
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVICT  = 6'b000010,
        S_INSERT = 6'b000100,
        S_ACK    = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FLUSH  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [6:0]       cap_reg;
    logic [1:0]       mode_reg;
    logic [31:0]      key_reg, tend_reg;
    logic [15:0]      actor_reg;
    logic [4:0]       filt_reg;
    selb_pkg::entry_t new_reg;
    logic [31:0]      oldest_reg, newest_reg;
    logic             pend_valid_reg, pend_valid_next;
    selb_pkg::entry_t pend_reg;

    logic             out_valid_reg;
    logic [1:0]       res_reg;
    selb_pkg::entry_t oent_reg;
    logic [CNT_W-1:0] ocnt_reg;
    logic [31:0]      oold_reg, onew_reg;
    logic             olast_reg;

    selb_pkg::cell_ctrl_t ctrl;
    selb_pkg::entry_t cells [DEPTH];
    logic             afters [DEPTH];

    logic       accept, out_free, step, hit, evict, out_load, o_last;
    logic [1:0] o_res;
    logic [6:0] cap;
    selb_pkg::entry_t o_ent;
    logic [31:0] o_old, o_new;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = (state_reg == S_SCAN) && (!pend_valid_reg || out_free);
    assign cap      = (cap_reg < 7'(DEPTH)) ? cap_reg : 7'(DEPTH);
    assign evict    = (fill_reg != '0) && (7'(fill_reg) >= cap);

    always_comb
    begin
        if (mode_reg == selb_pkg::MODE_RANGE)
            hit = (key_reg <= tend_reg) && (cells[0].time_s >= key_reg)
                  && (cells[0].time_s <= tend_reg);
        else
            hit = (cells[0].actor == actor_reg)
                  && (filt_reg[4] || ({1'b0, cells[0].kind} == filt_reg));
    end

    always_comb
    begin
        ctrl.key = key_reg;
        ctrl.op  = selb_pkg::OP_HOLD;
        if (state_reg == S_EVICT && evict)
            ctrl.op = selb_pkg::OP_SHIFT;
        else if (state_reg == S_INSERT)
            ctrl.op = selb_pkg::OP_INSERT;
        else if (step)
            ctrl.op = selb_pkg::OP_ROTATE;
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        selb_cell #(
            .CNT_W(CNT_W),
            .IDX  (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .fill       (fill_reg),
            .new_entry  (new_reg),
            .head_entry (cells[0]),
            .left_entry ((g == 0) ? new_reg : cells[(g == 0) ? 0 : g - 1]),
            .left_after ((g == 0) ? 1'b0 : afters[(g == 0) ? 0 : g - 1]),
            .right_entry(cells[(g == DEPTH - 1) ? g : g + 1]),
            .entry      (cells[g]),
            .after      (afters[g])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        out_load        = 1'b0;
        o_res           = selb_pkg::RES_ACK;
        o_ent           = '0;
        o_last          = 1'b0;
        o_old           = (fill_reg == '0) ? 32'd0 : oldest_reg;
        o_new           = (fill_reg == '0) ? 32'd0 : newest_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    case (mode)
                        selb_pkg::MODE_RECORD: state_next = S_EVICT;
                        selb_pkg::MODE_CLEAR:
                        begin
                            fill_next  = '0;
                            state_next = S_ACK;
                        end
                        default:
                        begin
                            state_next = (fill_reg == '0) ? S_FLUSH : S_SCAN;
                        end
                    endcase
                end
            end
            S_EVICT:
            begin
                if (evict)
                    fill_next = fill_reg - 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                fill_next  = fill_reg + 1'b1;
                state_next = S_ACK;
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    o_last     = 1'b1;
                    o_old      = (fill_reg == '0) ? 32'd0 : cells[0].time_s;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (step)
                begin
                    if (hit)
                    begin
                        // push the held match out, keep the new one back
                        out_load        = pend_valid_reg;
                        o_res           = selb_pkg::RES_ENTRY;
                        o_ent           = pend_reg;
                        pend_valid_next = 1'b1;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == fill_reg - 1'b1)
                        state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    o_last          = 1'b1;
                    o_res           = pend_valid_reg ? selb_pkg::RES_ENTRY
                                                     : selb_pkg::RES_EMPTY;
                    o_ent           = pend_valid_reg ? pend_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            cap_reg        <= selb_pkg::CAP_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we)
                cap_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            // stamp an unset time with the present time
            key_reg   <= (mode == selb_pkg::MODE_RECORD && event_time == 32'd0)
                         ? current_time : event_time;
            tend_reg  <= range_end;
            actor_reg <= actor_id;
            filt_reg  <= kind_filter;
            new_reg.time_s  <= (event_time == 32'd0) ? current_time : event_time;
            new_reg.actor   <= actor_id;
            new_reg.kind    <= event_kind;
            new_reg.x       <= pos_x;
            new_reg.y       <= pos_y;
            new_reg.z       <= pos_z;
            new_reg.payload <= payload;
        end
        if (state_reg == S_INSERT)
            newest_reg <= (fill_reg == '0 || newest_reg <= key_reg) ? key_reg : newest_reg;
        if (state_reg == S_ACK)
            oldest_reg <= cells[0].time_s;
        if (step && hit)
            pend_reg <= cells[0];
        if (out_load)
        begin
            res_reg   <= o_res;
            oent_reg  <= o_ent;
            ocnt_reg  <= fill_reg;
            oold_reg  <= o_old;
            onew_reg  <= o_new;
            olast_reg <= o_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = res_reg;
    assign out_time    = oent_reg.time_s;
    assign out_actor   = oent_reg.actor;
    assign out_kind    = oent_reg.kind;
    assign out_x       = oent_reg.x;
    assign out_y       = oent_reg.y;
    assign out_z       = oent_reg.z;
    assign out_payload = oent_reg.payload;
    assign entry_count = 7'(ocnt_reg);
    assign oldest_time = oold_reg;
    assign newest_time = onew_reg;
    assign last_of_run = olast_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input taken while an item is in progress");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind)
        && $stable(out_time) && $stable(last_of_run))
        else $error("stalled result dropped or changed");

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("held match left over in idle");

endmodule
`default_nettype wire

// ----- test/sorted_event_log_buffer_top_tb.sv -----
// Self-checking testbench for sorted_event_log_buffer_top: directed and random
// records, range and actor queries and clears, checked against a scoreboard.
// Depends on selb_pkg and the RTL of the event log buffer.
`timescale 1ns / 1ps

typedef struct {
    logic [1:0]  kind;
    logic [31:0] t;
    logic [15:0] actor;
    logic [3:0]  ekind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] pl;
    logic [6:0]  count;
    logic [31:0] oldest;
    logic [31:0] newest;
    logic        last;
} log_result_t;

class event_log_scoreboard;
    selb_pkg::entry_t log_entries[$];
    logic [6:0]  capacity;
    log_result_t pending[$];
    int          errors;
    int          checked;

    function new();
        capacity = selb_pkg::CAP_RESET;
        errors = 0;
        checked = 0;
    endfunction

    function log_result_t summary(logic [1:0] k);
        log_result_t r;
        r = '{default: '0};
        r.kind = k;
        r.count = 7'(log_entries.size());
        if (log_entries.size() > 0)
        begin
            r.oldest = log_entries[0].time_s;
            r.newest = log_entries[log_entries.size()-1].time_s;
        end
        return r;
    endfunction

    function void note_item(logic [1:0] md, selb_pkg::entry_t e, logic [31:0] now,
                            logic [31:0] tend, logic [4:0] filt);
        int cap;
        int pos;
        int first;
        log_result_t r;
        bit hit;
        first = pending.size();
        if (md == selb_pkg::MODE_RECORD)
        begin
            cap = (capacity > 64) ? 64 : capacity;
            if (log_entries.size() > 0 && log_entries.size() >= cap)
                void'(log_entries.pop_front());
            if (e.time_s == 0)
                e.time_s = now;
            pos = 0;
            while (pos < log_entries.size() && log_entries[pos].time_s <= e.time_s)
                pos++;
            log_entries.insert(pos, e);
            pending.push_back(summary(selb_pkg::RES_ACK));
        end
        else if (md == selb_pkg::MODE_CLEAR)
        begin
            log_entries.delete();
            pending.push_back(summary(selb_pkg::RES_ACK));
        end
        else
        begin
            foreach (log_entries[i])
            begin
                if (md == selb_pkg::MODE_RANGE)
                    hit = e.time_s <= tend && log_entries[i].time_s >= e.time_s
                          && log_entries[i].time_s <= tend;
                else
                    hit = log_entries[i].actor == e.actor
                          && (filt[4] || log_entries[i].kind == filt[3:0]);
                if (hit)
                begin
                    r = summary(selb_pkg::RES_ENTRY);
                    r.t = log_entries[i].time_s;
                    r.actor = log_entries[i].actor;
                    r.ekind = log_entries[i].kind;
                    r.x = log_entries[i].x;
                    r.y = log_entries[i].y;
                    r.z = log_entries[i].z;
                    r.pl = log_entries[i].payload;
                    pending.push_back(r);
                end
            end
            if (pending.size() == first)
                pending.push_back(summary(selb_pkg::RES_EMPTY));
        end
        pending[pending.size()-1].last = 1'b1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task check_result(log_result_t g);
        log_result_t w;
        checked++;
        if (pending.size() == 0)
        begin
            report("unexpected result", g.kind, 0);
            return;
        end
        w = pending.pop_front();
        if (g.kind   !== w.kind)   report("result_kind", g.kind, w.kind);
        if (g.t      !== w.t)      report("out_time", g.t, w.t);
        if (g.actor  !== w.actor)  report("out_actor", g.actor, w.actor);
        if (g.ekind  !== w.ekind)  report("out_kind", g.ekind, w.ekind);
        if (g.x      !== w.x)      report("out_x", g.x, w.x);
        if (g.y      !== w.y)      report("out_y", g.y, w.y);
        if (g.z      !== w.z)      report("out_z", g.z, w.z);
        if (g.pl     !== w.pl)     report("out_payload", g.pl, w.pl);
        if (g.count  !== w.count)  report("entry_count", g.count, w.count);
        if (g.oldest !== w.oldest) report("oldest_time", g.oldest, w.oldest);
        if (g.newest !== w.newest) report("newest_time", g.newest, w.newest);
        if (g.last   !== w.last)   report("last_of_run", g.last, w.last);
    endtask
endclass

module sorted_event_log_buffer_top_tb;
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [6:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         mode = selb_pkg::MODE_RECORD;
    logic [31:0]        event_time = '0;
    logic [31:0]        current_time = '0;
    logic [31:0]        range_end = '0;
    logic [15:0]        actor_id = '0;
    logic [3:0]         event_kind = '0;
    logic [4:0]         kind_filter = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic [31:0]        payload = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         result_kind;
    logic [31:0]        out_time;
    logic [15:0]        out_actor;
    logic [3:0]         out_kind;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_payload;
    logic [6:0]         entry_count;
    logic [31:0]        oldest_time;
    logic [31:0]        newest_time;
    logic               last_of_run;

    event_log_scoreboard sb = new();
    bit quiet_phase = 1'b0;
    int hold_off_cycles = 0;
    int n_items = 0;
    int n_records = 0;
    int n_queries = 0;
    logic [31:0] recent_times[$];

    sorted_event_log_buffer_top u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .event_time(event_time), .current_time(current_time),
        .range_end(range_end), .actor_id(actor_id), .event_kind(event_kind),
        .kind_filter(kind_filter), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .payload(payload), .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .out_time(out_time), .out_actor(out_actor),
        .out_kind(out_kind), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .out_payload(out_payload), .entry_count(entry_count),
        .oldest_time(oldest_time), .newest_time(newest_time),
        .last_of_run(last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, with a long hold-off when asked for.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 37);
    end

    always @(posedge clk)
    begin
        log_result_t g;
        if (rst_n && out_valid && !out_stall)
        begin
            g.kind = result_kind;  g.t = out_time;  g.actor = out_actor;
            g.ekind = out_kind;  g.x = out_x;  g.y = out_y;  g.z = out_z;
            g.pl = out_payload;  g.count = entry_count;  g.oldest = oldest_time;
            g.newest = newest_time;  g.last = last_of_run;
            sb.check_result(g);
        end
    end

    task send_item(logic [1:0] md, logic [31:0] t, logic [31:0] now,
                   logic [31:0] tend, logic [15:0] act, logic [3:0] ek,
                   logic [4:0] filt, logic [31:0] x, logic [31:0] y,
                   logic [31:0] z, logic [31:0] pl);
        selb_pkg::entry_t e;
        while (!quiet_phase && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;  event_time <= t;  current_time <= now;  range_end <= tend;
        actor_id <= act;  event_kind <= ek;  kind_filter <= filt;
        pos_x <= x;  pos_y <= y;  pos_z <= z;  payload <= pl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = '{time_s: t, actor: act, kind: ek, x: x, y: y, z: z, payload: pl};
        sb.note_item(md, e, now, tend, filt);
        n_items++;
        if (md == selb_pkg::MODE_RECORD)
        begin
            n_records++;
            recent_times.push_back(t == 0 ? now : t);
        end
        else if (md != selb_pkg::MODE_CLEAR)
            n_queries++;
    endtask

    task record_event(logic [31:0] t, logic [15:0] act, logic [3:0] ek);
        send_item(selb_pkg::MODE_RECORD, t, $urandom, $urandom, act, ek, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    task drain_and_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task write_capacity(logic [6:0] cap);
        cfg_we <= 1'b1;
        cfg_data <= cap;
        sb.capacity = cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function logic [31:0] pick_time();
        if (recent_times.size() > 0 && $urandom_range(2) == 0)
            return recent_times[$urandom_range(recent_times.size()-1)];
        return $urandom_range(15) == 0 ? $urandom : $urandom_range(1, 4000);
    endfunction

    task random_item();
        int sel;
        logic [31:0] a;
        logic [31:0] b;
        sel = $urandom_range(99);
        a = pick_time();
        b = pick_time();
        if (sel < 55)
            send_item(selb_pkg::MODE_RECORD, ($urandom_range(9) == 0) ? 32'd0 : a,
                      $urandom_range(1, 4000), $urandom, $urandom_range(3),
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (sel < 77)
            send_item(selb_pkg::MODE_RANGE, (a <= b || $urandom_range(4) == 0) ? a : b,
                      $urandom, (a <= b) ? b : a, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        else if (sel < 96)
            send_item(selb_pkg::MODE_ACTOR, $urandom, $urandom, $urandom,
                      ($urandom_range(7) == 0) ? $urandom : $urandom_range(3),
                      $urandom, ($urandom_range(2) == 0) ? 5'd16 + $urandom_range(15)
                      : $urandom_range(15), $urandom, $urandom, $urandom, $urandom);
        else
            send_item(selb_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int wait_cycles;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: queries on an empty store, field extremes, then range and actor query edges.
        send_item(selb_pkg::MODE_RANGE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_ACTOR, 0, 0, 0, 0, 0, 5'd16, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_RECORD, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 4'hF, 5'd0,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(selb_pkg::MODE_RECORD, 0, 32'd100, 32'hFFFF_FFFF, 0, 0, 5'h1F,
                  32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        send_item(selb_pkg::MODE_RECORD, 0, 0, 0, 16'h1234, 4'h5, 0, 1, -1, 2,
                  32'hA5A5_5A5A);
        record_event(32'd100, 16'h1234, 4'h5);
        record_event(32'd100, 16'h1234, 4'h6);
        record_event(32'd50, 16'hFFFF, 4'h0);
        send_item(selb_pkg::MODE_RANGE, 32'd100, 0, 32'd100, 0, 0, 0, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_RANGE, 32'd200, 0, 32'd100, 0, 0, 0, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_RANGE, 32'd101, 0, 32'd102, 0, 0, 0, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_RANGE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_ACTOR, 0, 0, 0, 16'h1234, 0, 5'd5, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_ACTOR, 0, 0, 0, 16'h1234, 0, 5'd16, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_ACTOR, 0, 0, 0, 16'h1234, 0, 5'h1F, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_ACTOR, 0, 0, 0, 16'h1234, 0, 5'd9, 0, 0, 0, 0);
        drain_and_idle();

        // Capacity lowered below the fill, then capacity zero, then raised to 127.
        write_capacity(7'd2);
        record_event(32'd10, 16'd1, 4'd1);
        record_event(32'd5, 16'd1, 4'd2);
        send_item(selb_pkg::MODE_RANGE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
        send_item(selb_pkg::MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        drain_and_idle();
        write_capacity(7'd0);
        record_event(32'd7, 16'd2, 4'd3);
        record_event(32'd8, 16'd2, 4'd3);
        drain_and_idle();
        write_capacity(7'd127);

        // Receiver holds off while the sender keeps offering items.
        quiet_phase = 1'b1;
        hold_off_cycles = 300;
        repeat (30) random_item();
        drain_and_idle();

        wait_cycles = 0;
        foreach (recent_times[i]) wait_cycles++;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_capacity(7'd1);
                1: write_capacity(7'd8);
                2: write_capacity(7'd64);
                default: write_capacity(7'd65);
            endcase
            recent_times.delete();
            quiet_phase = (phase == 2);
            repeat (phase == 2 ? 28 : 12) random_item();
            quiet_phase = 1'b0;
            send_item(selb_pkg::MODE_RANGE, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
            drain_and_idle();
        end

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        $display("Covered %0d transfers: %0d records, %0d queries, %0d results checked.",
                 n_items, n_records, n_queries, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/selb_pkg.sv
rtl/selb_cell.sv
rtl/sorted_event_log_buffer_top.sv
test/sorted_event_log_buffer_top_tb.sv
